// ===== src/first_fit_extent_allocator_assert.svh =====
// Assertion macros used by the allocator top level; clocked on clk_i, off while rst_ni is low.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define FFEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define FFEA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FFEA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ffea_pkg.sv =====
// Shared constants and types of the first-fit extent allocator.
`timescale 1ns / 1ps

package ffea_pkg;

  // Default bitmap size.
  localparam int unsigned NUM_BLOCKS_DEF = 256;

  // Block index / count width, fixed by the 9-bit register and length fields.
  localparam int unsigned BLK_W     = 9;
  // Bitmap row: blocks handled per cycle.
  localparam int unsigned ROW_BITS  = 8;
  localparam int unsigned ROW_SEL_W = 3;
  // Row index within the addressable block range.
  localparam int unsigned ROW_IDX_W = BLK_W - ROW_SEL_W;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_INVALID  = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  // Running state of the free-run search carried from row to row.
  typedef struct packed {
    logic [BLK_W-1:0] run;
    logic [BLK_W-1:0] first;
  } run_t;

  typedef struct packed {
    logic found;
    run_t carry;
  } scan_res_t;

endpackage

// ===== src/first_fit_extent_allocator.sv =====
// Top level of the first-fit extent allocator: sequencer, bitmap memory, result register.
`timescale 1ns / 1ps
//
// Command channel: an item (opcode_i, extent_length_i, extent_start_i) is taken at a
// rising edge with start high and busy low. Each item yields exactly one result word,
// shown on status_o / granted_start_o / granted_length_o / free_count_o for one cycle
// with res_strobe_o high. The receiver cannot stall; the result simply passes.
// Config channel: cfg_wdata_i is written to blocks_in_use when cfg_valid_i and
// cfg_ready_o are both high (ready in the clear pass, or while idle with start low).
// A write clears the bitmap and reloads the free count.
// Bitmap: NUM_BLOCKS bits in a memory of 8-bit rows, one row read or written per cycle.
// Clear pass: after reset and after each config write all ceil(NUM_BLOCKS/8) rows
// (32 by default) are zeroed, one per cycle; busy stays high meanwhile.
// Sequence from the accept edge to the result word:
//   - alloc rejected by length checks, or free of an empty range: result set at accept
//   - alloc: a read-ahead of the first row, R rows scanned (up to ceil(blocks_in_use/8)),
//     then W rows written for the grant; with no run found, the result follows the scan
//   - free: W rows written for the freed range
// Items are handled one at a time: a new item is taken only once busy has dropped,
// since the row scanner and the bitmap memory work through the rows in turn.

module first_fit_extent_allocator #(
  parameter int unsigned NUM_BLOCKS = ffea_pkg::NUM_BLOCKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode_i,
  input  logic [8:0]                  extent_length_i,
  input  logic [7:0]                  extent_start_i,
  // result
  output logic                        res_strobe_o,
  output logic [1:0]                  status_o,
  output logic [7:0]                  granted_start_o,
  output logic [8:0]                  granted_length_o,
  output logic [8:0]                  free_count_o,
  // config channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [8:0]                  cfg_wdata_i
);

  localparam int unsigned BLK_W    = ffea_pkg::BLK_W;
  localparam int unsigned ROW_BITS = ffea_pkg::ROW_BITS;
  localparam int unsigned ROW_IW   = ffea_pkg::ROW_IDX_W;
  localparam int unsigned ROWS     = (NUM_BLOCKS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned RA_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned RST_MGD  = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_MARK  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [BLK_W-1:0]        managed_q, managed_d;
  logic [BLK_W-1:0]        free_q, free_d;
  logic [RA_W-1:0]         clr_row_q, clr_row_d;
  logic [ROW_IW-1:0]       rd_row_q, rd_row_d;
  logic [ROW_IW-1:0]       row_p_q, row_p_d;
  logic                    pend_q, pend_d;
  ffea_pkg::run_t          carry_q, carry_d;
  logic [BLK_W-1:0]        len_q, len_d;
  logic [BLK_W-1:0]        lo_q, lo_d;
  logic [BLK_W-1:0]        hi_q, hi_d;
  logic [ROW_IW-1:0]       mark_row_q, mark_row_d;
  logic [ROW_IW-1:0]       last_row_q, last_row_d;
  logic                    mark_set_q, mark_set_d;
  logic                    strobe_q, strobe_d;
  ffea_pkg::status_e       status_q, status_d;
  logic [7:0]              gstart_q, gstart_d;
  logic [BLK_W-1:0]        glen_q, glen_d;
  logic [BLK_W-1:0]        fcount_q, fcount_d;

  // bitmap memory
  logic [ROW_BITS-1:0]     mem_q [ROWS];
  logic [ROW_BITS-1:0]     mem_rdata_q;
  logic                    mem_we;
  logic [RA_W-1:0]         mem_waddr;
  logic [ROW_BITS-1:0]     mem_wmask;
  logic                    mem_wval;
  logic [RA_W-1:0]         mem_raddr;

  logic [ROW_BITS-1:0]     mark_mask;
  ffea_pkg::scan_res_t     scan;
  logic                    scan_last;
  logic                    accept;
  logic                    cfg_we;
  logic [BLK_W:0]          free_sum;
  logic [BLK_W:0]          free_end;
  logic [BLK_W-1:0]        free_hi;
  logic [BLK_W-1:0]        grant_hi;

  // row of the last block in an extent ending (exclusive) at hi
  function automatic logic [ROW_IW-1:0] free_hi_m1_row(input logic [BLK_W-1:0] hi);
    logic [BLK_W-1:0] last_blk;
    last_blk = hi - 1'b1;
    return last_blk[BLK_W-1:ffea_pkg::ROW_SEL_W];
  endfunction

  assign busy         = (state_q != ST_IDLE);
  // no register write at an edge that takes a command word
  assign cfg_ready_o  = ((state_q == ST_IDLE) && !start) || (state_q == ST_CLEAR);
  assign accept       = start && !busy;
  assign cfg_we       = cfg_valid_i && cfg_ready_o;

  assign res_strobe_o     = strobe_q;
  assign status_o         = status_q;
  assign granted_start_o  = gstart_q;
  assign granted_length_o = glen_q;
  assign free_count_o     = fcount_q;

  ffea_row_scan u_row_scan (
    .row_i     (mem_rdata_q),
    .row_idx_i (row_p_q),
    .managed_i (managed_q),
    .len_i     (len_q),
    .carry_i   (carry_q),
    .res_o     (scan)
  );

  // last row holding managed blocks
  assign scan_last = ({1'b0, row_p_q, ffea_pkg::ROW_SEL_W'(0)} + (BLK_W + 1)'(ROW_BITS))
                     >= {1'b0, managed_q};

  assign free_sum = (BLK_W + 1)'(free_q) + (BLK_W + 1)'(extent_length_i);
  assign free_end = (BLK_W + 1)'(extent_start_i) + (BLK_W + 1)'(extent_length_i);
  assign free_hi  = (free_end > (BLK_W + 1)'(managed_q)) ? managed_q : free_end[BLK_W-1:0];
  assign grant_hi = scan.carry.first + len_q;

  // per-bit write mask of the row being marked: blocks in [lo, hi)
  always_comb begin
    logic [BLK_W-1:0] idx;
    for (int b = 0; b < ROW_BITS; b++) begin
      idx          = {mark_row_q, ffea_pkg::ROW_SEL_W'(b)};
      mark_mask[b] = (idx >= lo_q) && (idx < hi_q);
    end
  end

  assign mem_raddr = RA_W'(rd_row_q);

  always_comb begin
    state_d    = state_q;
    managed_d  = managed_q;
    free_d     = free_q;
    clr_row_d  = clr_row_q;
    rd_row_d   = rd_row_q;
    row_p_d    = row_p_q;
    pend_d     = pend_q;
    carry_d    = carry_q;
    len_d      = len_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mark_row_d = mark_row_q;
    last_row_d = last_row_q;
    mark_set_d = mark_set_q;
    strobe_d   = 1'b0;
    status_d   = status_q;
    gstart_d   = gstart_q;
    glen_d     = glen_q;
    fcount_d   = fcount_q;
    mem_we     = 1'b0;
    mem_waddr  = RA_W'(mark_row_q);
    mem_wmask  = mark_mask;
    mem_wval   = mark_set_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row_q;
        mem_wmask = '1;
        mem_wval  = 1'b0;
        clr_row_d = clr_row_q + 1'b1;
        if (clr_row_q == RA_W'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          status_d = ffea_pkg::STAT_OK;
          gstart_d = '0;
          glen_d   = '0;
          if (opcode_i == ffea_pkg::OP_ALLOC) begin
            fcount_d = free_q;
            if (extent_length_i > free_q) begin
              status_d = ffea_pkg::STAT_NO_SPACE;
              strobe_d = 1'b1;
            end else if (extent_length_i == '0 || extent_length_i > managed_q) begin
              status_d = ffea_pkg::STAT_INVALID;
              strobe_d = 1'b1;
            end else begin
              len_d    = extent_length_i;
              rd_row_d = '0;
              pend_d   = 1'b0;
              carry_d  = '0;
              state_d  = ST_SCAN;
            end
          end else begin
            // free: counter saturates at the managed count
            if (free_sum > (BLK_W + 1)'(managed_q)) begin
              free_d = managed_q;
            end else begin
              free_d = free_sum[BLK_W-1:0];
            end
            fcount_d = free_d;
            lo_d     = BLK_W'(extent_start_i);
            hi_d     = free_hi;
            if (BLK_W'(extent_start_i) >= free_hi) begin
              strobe_d = 1'b1;
            end else begin
              mark_row_d = ROW_IW'(extent_start_i[7:ffea_pkg::ROW_SEL_W]);
              last_row_d = free_hi_m1_row(free_hi);
              mark_set_d = 1'b0;
              state_d    = ST_MARK;
            end
          end
        end
      end

      ST_SCAN: begin
        // read of row k overlaps the scan of row k-1
        rd_row_d = rd_row_q + 1'b1;
        row_p_d  = rd_row_q;
        pend_d   = 1'b1;
        if (pend_q) begin
          if (scan.found) begin
            lo_d       = scan.carry.first;
            hi_d       = grant_hi;
            mark_row_d = scan.carry.first[BLK_W-1:ffea_pkg::ROW_SEL_W];
            last_row_d = free_hi_m1_row(grant_hi);
            mark_set_d = 1'b1;
            free_d     = free_q - len_q;
            fcount_d   = free_q - len_q;
            gstart_d   = scan.carry.first[7:0];
            glen_d     = len_q;
            state_d    = ST_MARK;
          end else if (scan_last) begin
            status_d = ffea_pkg::STAT_NO_SPACE;
            strobe_d = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            carry_d = scan.carry;
          end
        end
      end

      ST_MARK: begin
        mem_we     = 1'b1;
        mark_row_d = mark_row_q + 1'b1;
        if (mark_row_q == last_row_q) begin
          strobe_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register write: reload counts and restart the clear pass
    if (cfg_we) begin
      managed_d = (32'(cfg_wdata_i) > NUM_BLOCKS) ? BLK_W'(NUM_BLOCKS) : cfg_wdata_i;
      free_d    = managed_d;
      clr_row_d = '0;
      state_d   = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      managed_q  <= BLK_W'(RST_MGD);
      free_q     <= BLK_W'(RST_MGD);
      clr_row_q  <= '0;
      rd_row_q   <= '0;
      row_p_q    <= '0;
      pend_q     <= 1'b0;
      mark_row_q <= '0;
      last_row_q <= '0;
      mark_set_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      managed_q  <= managed_d;
      free_q     <= free_d;
      clr_row_q  <= clr_row_d;
      rd_row_q   <= rd_row_d;
      row_p_q    <= row_p_d;
      pend_q     <= pend_d;
      mark_row_q <= mark_row_d;
      last_row_q <= last_row_d;
      mark_set_q <= mark_set_d;
      strobe_q   <= strobe_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    carry_q  <= carry_d;
    len_q    <= len_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    status_q <= status_d;
    gstart_q <= gstart_d;
    glen_q   <= glen_d;
    fcount_q <= fcount_d;
  end

  // bitmap memory: one bit-masked row write, one registered row read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < ROW_BITS; b++) begin
        if (mem_wmask[b]) begin
          mem_q[mem_waddr][b] <= mem_wval;
        end
      end
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

`include "first_fit_extent_allocator_assert.svh"

  `FFEA_ASSERT(a_free_le_managed, free_q <= managed_q, "free count above managed count")
  `FFEA_ASSERT_IMP(a_mark_range, state_q == ST_MARK, lo_q < hi_q, "empty range in mark")
  `FFEA_ASSERT_IMP(a_fail_no_grant, res_strobe_o && status_o != ffea_pkg::STAT_OK, granted_start_o == '0 && granted_length_o == '0, "grant on failed item")
  `FFEA_ASSERT_NXT(a_accept_progress, start && !busy, busy || res_strobe_o, "item dropped")

endmodule

// ===== src/ffea_row_scan.sv =====
// Row scanner: extends the current run of free blocks across one bitmap row.
`timescale 1ns / 1ps

module ffea_row_scan (
  input  logic [ffea_pkg::ROW_BITS-1:0]  row_i,
  input  logic [ffea_pkg::ROW_IDX_W-1:0] row_idx_i,
  input  logic [ffea_pkg::BLK_W-1:0]     managed_i,
  input  logic [ffea_pkg::BLK_W-1:0]     len_i,
  input  ffea_pkg::run_t                 carry_i,
  output ffea_pkg::scan_res_t            res_o
);

  always_comb begin
    logic [ffea_pkg::BLK_W-1:0] idx;
    logic [ffea_pkg::BLK_W-1:0] run;
    logic [ffea_pkg::BLK_W-1:0] first;
    logic                       found;
    run   = carry_i.run;
    first = carry_i.first;
    found = 1'b0;
    for (int b = 0; b < ffea_pkg::ROW_BITS; b++) begin
      idx = {row_idx_i, ffea_pkg::ROW_SEL_W'(b)};
      if (!found) begin
        // blocks past the managed count act as used
        if (idx < managed_i && !row_i[b]) begin
          if (run == '0) begin
            first = idx;
          end
          run = run + 1'b1;
          if (run == len_i) begin
            found = 1'b1;
          end
        end else begin
          run = '0;
        end
      end
    end
    res_o.found       = found;
    res_o.carry.run   = run;
    res_o.carry.first = first;
  end

endmodule

// ===== sim/extent_checker.sv =====
// Checker for the extent allocator: predicts every result word and compares it on the strobe.
`timescale 1ns / 1ps

module extent_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  logic       opcode_i,
  input  logic [8:0] extent_length_i,
  input  logic [7:0] extent_start_i,
  input  logic       res_strobe_i,
  input  logic [1:0] status_i,
  input  logic [7:0] granted_start_i,
  input  logic [8:0] granted_length_i,
  input  logic [8:0] free_count_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [8:0] cfg_wdata_i,
  output int         pending_o,
  output int         mismatch_cnt_o
);

  localparam int unsigned NBLK = ffea_pkg::NUM_BLOCKS_DEF;

  typedef struct packed {
    ffea_pkg::status_e status;
    logic [7:0]        granted_start;
    logic [8:0]        granted_length;
    logic [8:0]        free_count;
  } grant_word_t;

  logic [NBLK-1:0] used_map;
  int unsigned     free_blocks;
  int unsigned     managed;
  grant_word_t     expected_grants[$];

  // Register write: clamp to the map size, clear the map, refill the counter.
  function automatic void load_blocks(logic [8:0] v);
    managed     = (v > NBLK) ? NBLK : v;
    used_map    = '0;
    free_blocks = managed;
  endfunction

  function automatic grant_word_t serve_extent(logic op, logic [8:0] len, logic [7:0] blk);
    grant_word_t w;
    int unsigned run, base, i;
    bit          found;
    w.status         = ffea_pkg::STAT_OK;
    w.granted_start  = '0;
    w.granted_length = '0;
    run   = 0;
    base  = 0;
    found = 1'b0;
    if (op == ffea_pkg::OP_ALLOC) begin
      if (len > free_blocks) begin
        w.status = ffea_pkg::STAT_NO_SPACE;
      end else if (len == 0 || len > managed) begin
        w.status = ffea_pkg::STAT_INVALID;
      end else begin
        // first fit, lowest block first
        for (i = 0; i < managed && !found; i++) begin
          if (used_map[i]) begin
            run = 0;
          end else begin
            if (run == 0) base = i;
            run++;
            found = (run == len);
          end
        end
        if (found) begin
          for (i = base; i < base + len; i++) used_map[i] = 1'b1;
          free_blocks      -= len;
          w.granted_start  = base[7:0];
          w.granted_length = len;
        end else begin
          w.status = ffea_pkg::STAT_NO_SPACE;
        end
      end
    end else begin
      // blocks past the managed range are dropped; the count still takes the full length
      for (i = blk; i < blk + len && i < managed; i++) used_map[i] = 1'b0;
      free_blocks += len;
      if (free_blocks > managed) free_blocks = managed;
    end
    w.free_count = free_blocks[8:0];
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_word_t want;
    int          errs;
    errs = 0;
    if (!rst_ni) begin
      load_blocks(9'd256);
      expected_grants.delete();
      pending_o      <= 0;
      mismatch_cnt_o <= 0;
    end else begin
      // results first: a word accepted at this edge cannot be answered at it
      if (res_strobe_i) begin
        if (expected_grants.size() == 0) begin
          $error("result word with nothing expected: status %0d, free_count %0d",
                 status_i, free_count_i);
          errs++;
        end else begin
          want = expected_grants.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            errs++;
          end
          if (granted_start_i !== want.granted_start) begin
            $error("granted_start: expected %0d, actual %0d",
                   want.granted_start, granted_start_i);
            errs++;
          end
          if (granted_length_i !== want.granted_length) begin
            $error("granted_length: expected %0d, actual %0d",
                   want.granted_length, granted_length_i);
            errs++;
          end
          if (free_count_i !== want.free_count) begin
            $error("free_count: expected %0d, actual %0d", want.free_count, free_count_i);
            errs++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) load_blocks(cfg_wdata_i);
      if (start_i && !busy_i) begin
        expected_grants.push_back(serve_extent(opcode_i, extent_length_i, extent_start_i));
      end
      pending_o      <= expected_grants.size();
      mismatch_cnt_o <= mismatch_cnt_o + errs;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top of the extent allocator: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;

  // Quiet-cycle limit: the slowest word (full scan plus a 32-row write) plus a
  // clear pass and a sender gap stays far below this.
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  localparam int unsigned NUM_PHASES      = 13;
  // Tail after the last result: covers the longest item the block could still run.
  localparam int unsigned DRAIN_CYCLES    = 100;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       start           = 1'b0;
  logic       busy;
  logic       opcode_i        = 1'b0;
  logic [8:0] extent_length_i = '0;
  logic [7:0] extent_start_i  = '0;
  logic       res_strobe_o;
  logic [1:0] status_o;
  logic [7:0] granted_start_o;
  logic [8:0] granted_length_o;
  logic [8:0] free_count_o;
  logic       cfg_valid_i     = 1'b0;
  logic       cfg_ready_o;
  logic [8:0] cfg_wdata_i     = '0;

  int pending;
  int mismatch_cnt;
  int words_sent   = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  first_fit_extent_allocator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .extent_length_i (extent_length_i),
    .extent_start_i  (extent_start_i),
    .res_strobe_o    (res_strobe_o),
    .status_o        (status_o),
    .granted_start_o (granted_start_o),
    .granted_length_o(granted_length_o),
    .free_count_o    (free_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  extent_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .opcode_i        (opcode_i),
    .extent_length_i (extent_length_i),
    .extent_start_i  (extent_start_i),
    .res_strobe_i    (res_strobe_o),
    .status_i        (status_o),
    .granted_start_i (granted_start_o),
    .granted_length_i(granted_length_o),
    .free_count_i    (free_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_wdata_i     (cfg_wdata_i),
    .pending_o       (pending),
    .mismatch_cnt_o  (mismatch_cnt)
  );

  // Watchdog: any accepted word, result or register write counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || res_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One command word. The sender idle rate changes over the run:
  // light gaps first, heavy gaps next, back to back at the end.
  // Each cycle start is dropped with the idle rate; the word goes at the first
  // edge with start high and busy low. start stays high on return.
  task automatic send_word(ffea_pkg::opcode_e op, logic [8:0] len, logic [7:0] blk);
    int idle_pct;
    bit go;
    idle_pct = (words_sent < 620) ? 19 : (words_sent < 1240) ? 61 : 0;
    opcode_i        <= op;
    extent_length_i <= len;
    extent_start_i  <= blk;
    forever begin
      go = !(idle_pct != 0 && $urandom_range(0, 99) < idle_pct);
      start <= go;
      @(posedge clk_i);
      if (go && !busy) break;
    end
    words_sent++;
  endtask

  // pending is registered in the checker, so it lags the queue it counts: the
  // do-while never trusts the value seen at the accepting edge.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Register write; the block takes it only while no word is in flight.
  task automatic write_blocks(logic [8:0] v);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [8:0]        settings [9];
    logic [8:0]        setting;
    int unsigned       managed_now, cap, pick;
    ffea_pkg::opcode_e op;
    logic [8:0]        len;
    logic [7:0]        blk;

    // extremes first: smallest, zero, full, oversized (clamped), all ones
    settings = '{9'd1, 9'd0, 9'd256, 9'd300, 9'd511, 9'd8, 9'd13, 9'd64, 9'd100};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words on the reset map (256 blocks, all free).
    send_word(ffea_pkg::OP_ALLOC, 9'd0,   8'd0);    // zero length: invalid
    send_word(ffea_pkg::OP_ALLOC, 9'd256, 8'd255);  // whole map, start field ignored
    send_word(ffea_pkg::OP_ALLOC, 9'd1,   8'd0);    // longer than the free count: no space
    send_word(ffea_pkg::OP_ALLOC, 9'd0,   8'd0);    // zero length with nothing free
    send_word(ffea_pkg::OP_FREE,  9'd0,   8'd0);    // empty range
    send_word(ffea_pkg::OP_FREE,  9'd256, 8'd255);  // runs off the end; count takes the full length
    send_word(ffea_pkg::OP_FREE,  9'd256, 8'd0);    // clear everything
    send_word(ffea_pkg::OP_ALLOC, 9'd128, 8'd0);
    send_word(ffea_pkg::OP_ALLOC, 9'd128, 8'd0);
    send_word(ffea_pkg::OP_FREE,  9'd64,  8'd64);
    send_word(ffea_pkg::OP_FREE,  9'd64,  8'd192);
    send_word(ffea_pkg::OP_ALLOC, 9'd100, 8'd0);    // enough free blocks but no run
    send_word(ffea_pkg::OP_ALLOC, 9'd64,  8'd0);    // exact fit in the first hole
    send_word(ffea_pkg::OP_FREE,  9'd64,  8'd64);
    send_word(ffea_pkg::OP_FREE,  9'd10,  8'd70);   // already free, still counted
    send_word(ffea_pkg::OP_ALLOC, 9'd3,   8'd0);
    send_word(ffea_pkg::OP_ALLOC, 9'd200, 8'd0);
    send_word(ffea_pkg::OP_FREE,  9'd1,   8'd255);
    send_word(ffea_pkg::OP_FREE,  9'd256, 8'd0);

    managed_now = 256;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        // map must be idle: every word answered before the write
        start <= 1'b0;
        wait_drained();
        setting = (p <= 9) ? settings[p-1] : 9'($urandom_range(1, 256));
        write_blocks(setting);
        managed_now = (setting > 256) ? 256 : setting;
      end
      cap = (managed_now > 8) ? managed_now / 8 : 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // allocations, mostly small so the map fragments
          op  = ffea_pkg::OP_ALLOC;
          len = (pick < 40) ? 9'($urandom_range(1, cap))
                            : 9'($urandom_range(1, (managed_now > 0) ? managed_now : 1));
          blk = 8'($urandom_range(0, 255));
        end else if (pick < 92) begin
          // frees inside the managed range punch holes
          op  = ffea_pkg::OP_FREE;
          blk = 8'($urandom_range(0, (managed_now > 0) ? managed_now - 1 : 0));
          len = 9'($urandom_range(1, cap));
        end else begin
          // noise: either opcode, any start block, any length from 0 to 256
          op  = ffea_pkg::opcode_e'($urandom_range(0, 1));
          len = 9'($urandom_range(0, 256));
          blk = 8'($urandom_range(0, 255));
        end
        send_word(op, len, blk);
      end
    end

    start <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ffea_pkg.sv
src/ffea_row_scan.sv
src/first_fit_extent_allocator.sv
sim/extent_checker.sv
sim/tb_top.sv
